// ----- rtl/assert_macros.svh -----
// Assertion helpers for the list checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define PAL_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// Overlapping implication outside reset.
`define PAL_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define PAL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pal_pkg.sv -----
package pal_pkg;

    localparam int DEF_CAPACITY = 128;

    localparam int POS_W   = 8;
    localparam int ID_W    = 32;
    localparam int SCORE_W = 32;
    localparam int ENT_W   = ID_W + SCORE_W;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 88;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_DELETE = 3'd1,
        FN_LOCATE = 3'd2,
        FN_READ   = 3'd3,
        FN_CLEAR  = 3'd4
    } func_t;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd2;

    // entry layout: id in the low half, score bits in the high half
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             loc;
        logic [ENT_W-1:0] key;
    } cell_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [ENT_W-1:0] data;
    } lane_t;

endpackage

// ----- rtl/pal_cell.sv -----
module pal_cell #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0,
    parameter int LEN_W    = $clog2(CAPACITY + 1),
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                     aclk,
    input  pal_pkg::cell_cmd_t       cmd,
    input  logic [pal_pkg::POS_W-1:0] pos,
    input  logic [LEN_W-1:0]         len,
    input  logic [pal_pkg::ENT_W-1:0] left_ent,
    input  logic [pal_pkg::ENT_W-1:0] right_ent,
    output logic [pal_pkg::ENT_W-1:0] ent_o,
    input  pal_pkg::lane_t           carry_in,
    input  logic [IDX_W-1:0]         carry_idx_in,
    output pal_pkg::lane_t           carry_o,
    output logic [IDX_W-1:0]         carry_idx_o
);

    localparam int CMP_W = ((LEN_W > pal_pkg::POS_W) ? LEN_W : pal_pkg::POS_W) + 1;
    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [pal_pkg::ENT_W-1:0] entry_reg, entry_next;
    pal_pkg::lane_t            carry_reg, carry_next;
    logic [IDX_W-1:0]          carry_idx_reg, carry_idx_next;
    logic [CMP_W-1:0]          pos_w, len_w;
    logic                      match;

    assign pos_w = CMP_W'(pos);
    assign len_w = CMP_W'(len);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (MY_POS == pos_w) begin
                entry_next = cmd.key;
            end else if (MY_POS > pos_w) begin
                entry_next = left_ent;
            end
        end else if (cmd.del) begin
            if (MY_POS >= pos_w) begin
                entry_next = right_ent;
            end
        end
    end

    // a hit here overrides whatever came down from higher cells
    assign match = cmd.loc ? ((entry_reg == cmd.key) && (MY_POS <= len_w))
                           : (MY_POS == pos_w);

    always_comb begin
        if (match) begin
            carry_next.hit  = 1'b1;
            carry_next.data = entry_reg;
            carry_idx_next  = MY_IDX;
        end else begin
            carry_next      = carry_in;
            carry_idx_next  = carry_idx_in;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg     <= entry_next;
        carry_reg     <= carry_next;
        carry_idx_reg <= carry_idx_next;
    end

    assign ent_o       = entry_reg;
    assign carry_o     = carry_reg;
    assign carry_idx_o = carry_idx_reg;

endmodule

// ----- rtl/pal_ctrl.sv -----
module pal_ctrl #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY,
    parameter int LEN_W    = $clog2(CAPACITY + 1),
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pal_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [pal_pkg::FUNC_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pal_pkg::M_DATA_W-1:0] m_tdata,
    output pal_pkg::cell_cmd_t           cmd,
    output logic [pal_pkg::POS_W-1:0]    pos_o,
    output logic [LEN_W-1:0]             len_o,
    input  pal_pkg::lane_t               lane,
    input  logic [IDX_W-1:0]             lane_idx
);

    localparam int CMP_W = ((LEN_W > pal_pkg::POS_W) ? LEN_W : pal_pkg::POS_W) + 1;
    localparam logic [LEN_W-1:0] CAP_LEN  = LEN_W'(CAPACITY);
    localparam logic [LEN_W-1:0] LAST_CNT = LEN_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [LEN_W-1:0]           cnt_reg, cnt_next;
    logic                       loc_reg, loc_next;
    logic [pal_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [pal_pkg::ENT_W-1:0]  key_reg, key_next;

    logic                       m_valid_reg, m_valid_next;
    logic [pal_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [pal_pkg::POS_W-1:0]  found_reg, found_next;
    logic [pal_pkg::ENT_W-1:0]  rdata_reg, rdata_next;
    logic [pal_pkg::POS_W-1:0]  olen_reg, olen_next;
    logic                       load;

    logic                       accept, out_free;
    logic [pal_pkg::POS_W-1:0]  in_pos;
    logic [pal_pkg::ENT_W-1:0]  in_key;
    logic [CMP_W-1:0]           pos_w, len_w, len_p1_w, idx_p1_w;
    logic                       ins_now, del_now;

    assign in_pos = s_tdata[7:0];
    assign in_key = s_tdata[71:8];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign pos_w    = CMP_W'(in_pos);
    assign len_w    = CMP_W'(len_reg);
    assign len_p1_w = len_w + CMP_W'(1);
    assign idx_p1_w = CMP_W'(lane_idx) + CMP_W'(1);

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        loc_next   = loc_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        ins_now    = 1'b0;
        del_now    = 1'b0;
        load       = 1'b0;
        stat_next  = pal_pkg::STAT_OK;
        found_next = '0;
        rdata_next = '0;
        olen_next  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pos_next = in_pos;
                    key_next = in_key;
                    cnt_next = '0;
                    unique case (pal_pkg::func_t'(s_tuser))
                        pal_pkg::FN_INSERT: begin
                            load = 1'b1;
                            if (len_reg == CAP_LEN) begin
                                stat_next = pal_pkg::STAT_FULL;
                            end else if (pos_w == '0 || pos_w > len_p1_w) begin
                                stat_next = pal_pkg::STAT_BAD_POS;
                            end else begin
                                ins_now  = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        pal_pkg::FN_DELETE: begin
                            load = 1'b1;
                            if (pos_w == '0 || pos_w > len_w) begin
                                stat_next = pal_pkg::STAT_BAD_POS;
                            end else begin
                                del_now  = 1'b1;
                                len_next = len_reg - LEN_W'(1);
                            end
                        end
                        pal_pkg::FN_LOCATE: begin
                            loc_next   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        pal_pkg::FN_READ: begin
                            if (pos_w == '0 || pos_w > len_w) begin
                                load      = 1'b1;
                                stat_next = pal_pkg::STAT_BAD_POS;
                            end else begin
                                loc_next   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        pal_pkg::FN_CLEAR: begin
                            load     = 1'b1;
                            len_next = '0;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                    olen_next = (pal_pkg::POS_W)'(len_next);
                end
            end
            ST_SCAN: begin
                // wait for the wave to reach the bottom cell
                if (cnt_reg == LAST_CNT) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            ST_DONE: begin
                load      = 1'b1;
                olen_next = (pal_pkg::POS_W)'(len_reg);
                if (loc_reg) begin
                    found_next = lane.hit ? idx_p1_w[pal_pkg::POS_W-1:0]
                                          : len_p1_w[pal_pkg::POS_W-1:0];
                end else begin
                    rdata_next = lane.data;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cnt_reg     <= '0;
            loc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            loc_reg     <= loc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        if (load) begin
            stat_reg  <= stat_next;
            found_reg <= found_next;
            rdata_reg <= rdata_next;
            olen_reg  <= olen_next;
        end
    end

    // cells see the live input on the accept cycle, the held copy during a scan
    assign cmd.ins = ins_now;
    assign cmd.del = del_now;
    assign cmd.loc = loc_reg;
    assign cmd.key = (state_reg == ST_IDLE) ? in_key : key_reg;
    assign pos_o   = (state_reg == ST_IDLE) ? in_pos : pos_reg;
    assign len_o   = len_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, olen_reg, rdata_reg, found_reg, stat_reg};

endmodule

// ----- rtl/positional_array_list.sv -----
// Insert, delete, clear, any unused code and a read at a bad position: result valid in the
// cycle after the transfer, one transfer per cycle while the sink keeps up.
// Locate and a valid read: the result is loaded in the DONE state, after the SCAN state has
// waited for the result lane that walks from the top cell down to cell 0; input is held off
// meanwhile, and the next transfer is taken once back in IDLE with the output register free.
// Reset (aresetn low, synchronous) empties the list; stored records are not cleared.
module positional_array_list #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // position[7:0], student_id[39:8], score_bits[71:40]
    input  logic [pal_pkg::S_DATA_W-1:0] s_tdata,
    // func[2:0]
    input  logic [pal_pkg::FUNC_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], found_position[9:2], read_id[41:10], read_score_bits[73:42],
    // list_length[81:74], zero fill above
    output logic [pal_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    pal_pkg::cell_cmd_t        cmd;
    logic [pal_pkg::POS_W-1:0] pos;
    logic [LEN_W-1:0]          len;

    logic [pal_pkg::ENT_W-1:0] ent   [CAPACITY];
    pal_pkg::lane_t            carry [CAPACITY];
    logic [IDX_W-1:0]          cidx  [CAPACITY];

    pal_ctrl #(
        .CAPACITY (CAPACITY),
        .LEN_W    (LEN_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .pos_o    (pos),
        .len_o    (len),
        .lane     (carry[0]),
        .lane_idx (cidx[0])
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [pal_pkg::ENT_W-1:0] left_ent, right_ent;
        pal_pkg::lane_t            carry_in;
        logic [IDX_W-1:0]          cidx_in;

        if (i == 0) begin : g_first
            assign left_ent = ent[i];
        end else begin : g_mid_l
            assign left_ent = ent[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_ent = ent[i];
            assign carry_in  = '0;
            assign cidx_in   = '0;
        end else begin : g_mid_r
            assign right_ent = ent[i+1];
            assign carry_in  = carry[i+1];
            assign cidx_in   = cidx[i+1];
        end

        pal_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i),
            .LEN_W    (LEN_W),
            .IDX_W    (IDX_W)
        ) u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .pos          (pos),
            .len          (len),
            .left_ent     (left_ent),
            .right_ent    (right_ent),
            .ent_o        (ent[i]),
            .carry_in     (carry_in),
            .carry_idx_in (cidx_in),
            .carry_o      (carry[i]),
            .carry_idx_o  (cidx[i])
        );
    end

endmodule

// ----- rtl/pal_checker.sv -----
`include "assert_macros.svh"

module pal_checker #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pal_pkg::M_DATA_W-1:0] m_tdata
);

    localparam logic [pal_pkg::POS_W:0] CAP_W = (pal_pkg::POS_W + 1)'(CAPACITY);

    logic [pal_pkg::STAT_W-1:0] stat;
    logic [pal_pkg::POS_W:0]    olen;
    logic                       out_stall, in_xfer, stat_legal, len_chk, full_seen;

    assign stat = m_tdata[1:0];
    assign olen = {1'b0, m_tdata[81:74]};

    assign out_stall  = m_tvalid && !m_tready;
    assign in_xfer    = s_tvalid && s_tready;
    assign stat_legal = (stat == pal_pkg::STAT_OK) || (stat == pal_pkg::STAT_FULL)
                        || (stat == pal_pkg::STAT_BAD_POS);
    assign len_chk    = m_tvalid && (CAPACITY < 256);
    assign full_seen  = len_chk && (stat == pal_pkg::STAT_FULL);

    // a stalled result keeps its payload
    `PAL_ASSERT_NEXT(a_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata), "payload moved")

    // input is only taken when the output register can take the result
    `PAL_ASSERT_IMPL(a_room, aclk, aresetn, in_xfer, !out_stall, "input while blocked")

    `PAL_ASSERT_IMPL(a_status, aclk, aresetn, m_tvalid, stat_legal, "illegal status code")

    `PAL_ASSERT_IMPL(a_len, aclk, aresetn, len_chk, olen <= CAP_W, "length above capacity")

    // a full refusal always reports the list length at capacity
    `PAL_ASSERT_IMPL(a_full, aclk, aresetn, full_seen, olen == CAP_W, "full with room left")

endmodule

bind positional_array_list pal_checker #(
    .CAPACITY (CAPACITY)
) u_pal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
